### rtl/core/plip_pkg.sv
// ----------------------------------------------------------------------------
// plip_pkg
// Shared types and codes for the piecewise-linear profile interpolator.
// ----------------------------------------------------------------------------
package plip_pkg;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int unsigned DIV_STEPS = 64;

	typedef enum logic [1:0] {
		RA_ZERO,
		RA_ONE,
		RA_LAST,
		RA_NEXT
	} ra_sel_t;

	typedef struct packed {
		logic    cap;
		logic    wr;
		logic    clr;
		logic    set_empty;
		logic    set_full;
		ra_sel_t rd_sel;
		logic    ld_prev;
		logic    ld_cur;
		logic    idx_one;
		logic    idx_inc;
		logic    prod;
		logic    div;
		logic    lerp;
		logic    y_first;
		logic    mul;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       empty;
		logic       full;
		logic       neg;
		logic       below_first;
		logic       flu_zero;
		logic       above_last;
		logic       single;
		logic       hit;
		logic       idx_last;
		logic       div_done;
	} dp_stat_t;

endpackage

### rtl/core/plip_if.sv
// ----------------------------------------------------------------------------
// plip_req_if / plip_rsp_if
// Valid/ready channels for requests and results of the profile interpolator.
// ----------------------------------------------------------------------------
interface plip_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] depth;
	logic [31:0]        density;

	modport source (output valid, operation, depth, density, input ready);
	modport sink   (input valid, operation, depth, density, output ready);
endinterface

interface plip_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] concentration;
	logic [1:0]  status;

	modport source (output valid, concentration, status, input ready);
	modport sink   (input valid, concentration, status, output ready);
endinterface

### rtl/core/piecewise_linear_profile_interp_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_profile_interp_core
// Depth profile table with linear interpolation, scaled by fluence.
// ----------------------------------------------------------------------------
// req carries one request (operation, depth, density); rsp returns one result
// (concentration, status) per request, in order. cfg_we/cfg_wdata write the
// fluence register; the user must do so only while the block is idle, as the
// block itself does not enforce it. One request is worked on at a time. Append,
// clear and unused codes pass through dispatch and finish; queries that exit
// early stop at dispatch or at the first or last entry check. A segment search
// reads one table entry per cycle from the single RAM read port; a registered
// multiply, a bit-serial divider and a second registered multiply then follow.
// A new request is taken as soon as the previous result is in the output
// register, even while rsp is stalled; that request then waits to be
// delivered until the output register is free.
// Reset empties the table (fill count to zero, no memory sweep) and clears
// fluence to zero; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module piecewise_linear_profile_interp_core #(
	parameter int MAX_POINTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	plip_req_if.sink    req,
	plip_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import plip_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	plip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	plip_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_operation      (req.operation),
		.in_depth          (req.depth),
		.in_density        (req.density),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.out_concentration (rsp.concentration),
		.out_status        (rsp.status)
	);
endmodule

### rtl/core/plip_ram.sv
// ----------------------------------------------------------------------------
// plip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/core/plip_dp.sv
// ----------------------------------------------------------------------------
// plip_dp
// Datapath: point table, segment search registers, divider and multipliers.
// ----------------------------------------------------------------------------
module plip_dp #(
	parameter int MAX_POINTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  plip_pkg::dp_cmd_t  cmd,
	output plip_pkg::dp_stat_t stat,
	input  logic [1:0]         in_operation,
	input  logic signed [31:0] in_depth,
	input  logic [31:0]        in_density,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	output logic [63:0]        out_concentration,
	output logic [1:0]         out_status
);
	import plip_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [1:0]         op_q;
	logic signed [31:0] x_q;
	logic [31:0]        dens_q;
	logic [31:0]        fluence_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic signed [31:0] prev_d_q, cur_d_q;
	logic [31:0]        prev_y_q, cur_y_q;
	logic [63:0]        p_q;
	logic [31:0]        rem_q, q_q, span_q, y_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic [63:0]        res_q;
	logic [1:0]         st_q;

	logic [CW-1:0]      cnt_m1;
	logic [AW-1:0]      raddr;
	logic [63:0]        rdata;
	logic signed [31:0] rd_d;
	logic [31:0]        rd_y;
	logic [32:0]        dx_w, span_w, trial, diff;
	logic [31:0]        dy;
	logic               ge;

	assign cnt_m1 = count_q - CW'(1);
	assign rd_d   = signed'(rdata[63:32]);
	assign rd_y   = rdata[31:0];

	always_comb begin
		case (cmd.rd_sel)
			RA_ZERO: raddr = '0;
			RA_ONE:  raddr = AW'(1);
			RA_LAST: raddr = cnt_m1[AW-1:0];
			RA_NEXT: raddr = idx_q + AW'(1);
			default: raddr = '0;
		endcase
	end

	plip_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (count_q[AW-1:0]),
		.wdata ({x_q, dens_q}),
		.re    (1'b1),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign dx_w   = 33'({x_q[31], x_q} - {prev_d_q[31], prev_d_q});
	assign span_w = 33'({cur_d_q[31], cur_d_q} - {prev_d_q[31], prev_d_q});
	assign dy     = (cur_y_q >= prev_y_q) ? cur_y_q - prev_y_q : prev_y_q - cur_y_q;
	assign trial  = {rem_q, p_q[63]};
	assign diff   = trial - {1'b0, span_q};
	assign ge     = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fluence_q <= '0;
			count_q   <= '0;
		end else begin
			if (cfg_we) begin
				fluence_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.wr) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= in_operation;
			x_q    <= in_depth;
			dens_q <= in_density;
			res_q  <= '0;
			st_q   <= ST_OK;
		end
		if (cmd.set_empty) begin
			st_q <= ST_EMPTY;
		end
		if (cmd.set_full) begin
			st_q <= ST_FULL;
		end
		if (cmd.ld_prev) begin
			prev_d_q <= rd_d;
			prev_y_q <= rd_y;
		end
		if (cmd.ld_cur) begin
			cur_d_q <= rd_d;
			cur_y_q <= rd_y;
		end
		if (cmd.idx_one) begin
			idx_q <= AW'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.prod) begin
			p_q    <= 64'(dy) * 64'(dx_w[31:0]);
			span_q <= span_w[31:0];
			neg_q  <= cur_y_q < prev_y_q;
			rem_q  <= '0;
			q_q    <= '0;
			cnt_q  <= '0;
		end
		if (cmd.div) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			q_q   <= {q_q[30:0], ge};
			p_q   <= {p_q[62:0], 1'b0};
			cnt_q <= cnt_q + 6'd1;
		end
		if (cmd.y_first) begin
			y_q <= rd_y;
		end else if (cmd.lerp) begin
			y_q <= neg_q ? prev_y_q - q_q : prev_y_q + q_q;
		end
		if (cmd.mul) begin
			res_q <= 64'(fluence_q) * 64'(y_q);
		end
		if (cmd.out_load) begin
			out_concentration <= res_q;
			out_status        <= st_q;
		end
	end

	assign stat.op          = op_q;
	assign stat.empty       = count_q == '0;
	assign stat.full        = count_q == CW'(MAX_POINTS);
	assign stat.neg         = x_q < 0;
	assign stat.below_first = x_q < rd_d;
	assign stat.flu_zero    = fluence_q == '0;
	assign stat.above_last  = x_q > rd_d;
	assign stat.single      = count_q == CW'(1);
	assign stat.hit         = (x_q >= prev_d_q) && (x_q < rd_d);
	assign stat.idx_last    = idx_q == cnt_m1[AW-1:0];
	assign stat.div_done    = cnt_q == 6'(DIV_STEPS - 1);
endmodule

### rtl/core/plip_ctrl.sv
// ----------------------------------------------------------------------------
// plip_ctrl
// Controller: sequences table updates, segment search, divide and multiply.
// ----------------------------------------------------------------------------
module plip_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output plip_pkg::dp_cmd_t  cmd,
	input  plip_pkg::dp_stat_t stat
);
	import plip_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_DISPATCH = 10'b0000000010,
		S_FIRST    = 10'b0000000100,
		S_LAST     = 10'b0000001000,
		S_SCAN     = 10'b0000010000,
		S_PROD     = 10'b0000100000,
		S_DIV      = 10'b0001000000,
		S_LERP     = 10'b0010000000,
		S_MUL      = 10'b0100000000,
		S_FINISH   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   emit;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign emit      = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RA_ZERO;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				if (stat.op == OP_APPEND) begin
					cmd.wr       = !stat.full;
					cmd.set_full = stat.full;
				end else if (stat.op == OP_CLEAR) begin
					cmd.clr = 1'b1;
				end else if (stat.op == OP_QUERY) begin
					if (stat.empty) begin
						cmd.set_empty = 1'b1;
					end else if (!stat.neg) begin
						cmd.rd_sel = RA_ZERO;
						state_d    = S_FIRST;
					end
				end
			end
			S_FIRST: begin
				cmd.ld_prev = 1'b1;
				if (stat.below_first) begin
					cmd.y_first = 1'b1;
					state_d     = S_MUL;
				end else if (stat.flu_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_sel = RA_LAST;
					state_d    = S_LAST;
				end
			end
			S_LAST: begin
				if (stat.above_last || stat.single) begin
					state_d = S_FINISH;
				end else begin
					cmd.rd_sel  = RA_ONE;
					cmd.idx_one = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					cmd.ld_cur = 1'b1;
					state_d    = S_PROD;
				end else if (stat.idx_last) begin
					state_d = S_FINISH;
				end else begin
					cmd.ld_prev = 1'b1;
					cmd.idx_inc = 1'b1;
					cmd.rd_sel  = RA_NEXT;
				end
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (stat.div_done) begin
					state_d = S_LERP;
				end
			end
			S_LERP: begin
				cmd.lerp = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (emit) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

### sim/plip_tb_if.sv
// ----------------------------------------------------------------------------
// plip_tb_pkg
// Result type and extra operation code for the profile interpolator testbench.
// ----------------------------------------------------------------------------
package plip_tb_pkg;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [63:0] concentration;
		logic [1:0]  status;
	} profile_result_t;

endpackage

### sim/tb_piecewise_linear_profile_interp_core.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_profile_interp_core
// Drives appends, queries, clears and unused codes into the profile interpolator, predicts
// each result from a local copy of the table and fluence, and compares them.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_profile_interp_core;
	timeunit 1ns;
	timeprecision 1ps;
	import plip_pkg::*;
	import plip_tb_pkg::*;

	localparam int TABLE_SIZE = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	plip_req_if req ();
	plip_rsp_if rsp ();

	piecewise_linear_profile_interp_core #(.MAX_POINTS(TABLE_SIZE)) DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	logic signed [31:0] pt_depth [TABLE_SIZE];
	logic [31:0]        pt_dens  [TABLE_SIZE];
	int unsigned        pt_count;
	logic [31:0]        flu_model;
	profile_result_t    expected_results [$];
	int                 mismatches;
	bit                 long_holdoff;
	bit                 no_stalls;

	function automatic logic [31:0] lerp_dens(longint x, longint x1, logic [31:0] y1,
			longint x2, logic [31:0] y2);
		logic [63:0] dx, span, mag;
		dx = 64'(x - x1);
		span = 64'(x2 - x1);
		if (span == 0) return y1;
		if (y2 >= y1) begin
			mag = (64'(y2 - y1) * dx) / span;
			return y1 + mag[31:0];
		end
		mag = (64'(y1 - y2) * dx) / span;
		return y1 - mag[31:0];
	endfunction

	function automatic profile_result_t predict_concentration(logic [1:0] op,
			logic signed [31:0] d, logic [31:0] dens);
		profile_result_t r;
		longint x;
		r = '{concentration: '0, status: ST_OK};
		x = d;
		case (op)
			OP_APPEND: begin
				if (pt_count < TABLE_SIZE) begin
					pt_depth[pt_count] = d;
					pt_dens[pt_count] = dens;
					pt_count++;
				end else r.status = ST_FULL;
			end
			OP_CLEAR: pt_count = 0;
			OP_QUERY: begin
				if (pt_count == 0) r.status = ST_EMPTY;
				else if (x < 0) ;
				else if (x < longint'(pt_depth[0]))
					r.concentration = 64'(flu_model) * 64'(pt_dens[0]);
				else if (flu_model == 0) ;
				else if (x > longint'(pt_depth[pt_count-1])) ;
				else begin
					for (int i = 0; i + 1 < pt_count; i++) begin
						if (x >= longint'(pt_depth[i]) && x < longint'(pt_depth[i+1])) begin
							r.concentration = 64'(flu_model) * 64'(lerp_dens(x,
								pt_depth[i], pt_dens[i], pt_depth[i+1], pt_dens[i+1]));
							break;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(logic [1:0] op, logic signed [31:0] d, logic [31:0] dens);
		int gap;
		@(negedge clk);
		if (!no_stalls && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.depth <= d;
		req.density <= dens;
		do @(posedge clk); while (!req.ready);
		expected_results.insert(expected_results.size(), predict_concentration(op, d, dens));
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic write_fluence(logic [31:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		flu_model = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_edges();
		send_request(OP_QUERY, 32'sd100, '0);
		write_fluence(32'hFFFF_FFFF);
		send_request(OP_APPEND, 32'sd256, 32'hFFFF_FFFF);
		send_request(OP_QUERY, 32'sd100, '0);
		send_request(OP_QUERY, 32'sd256, '0);
		send_request(OP_QUERY, -32'sd1, '0);
		send_request(OP_QUERY, 32'sh8000_0000, '0);
		send_request(OP_APPEND, 32'sd1024, 32'h0000_0000);
		send_request(OP_APPEND, 32'sh7FFF_FFFF, 32'h8000_0001);
		send_request(OP_QUERY, 32'sd600, 32'hFFFF_FFFF);
		send_request(OP_QUERY, 32'sd1024, '0);
		send_request(OP_QUERY, 32'sh7FFF_FFFE, '0);
		send_request(OP_QUERY, 32'sh7FFF_FFFF, '0);
		send_request(OP_UNUSED, 32'sd5, 32'd5);
		send_request(OP_APPEND, 32'sd10, 32'd77);
		send_request(OP_QUERY, 32'sh7FFF_FFFF, '0);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_APPEND, '0, 32'd1234);
		send_request(OP_QUERY, '0, '0);
		send_request(OP_QUERY, 32'sd5, '0);
		write_fluence('0);
		send_request(OP_QUERY, '0, '0);
		send_request(OP_APPEND, 32'sd50, 32'd99);
		send_request(OP_QUERY, 32'sd20, '0);
	endtask

	task automatic load_profile(int n);
		logic signed [31:0] d;
		d = $urandom_range(0, 3) == 0 ? -$signed(32'($urandom_range(0, 1000))) :
			32'($urandom_range(0, 2000));
		send_request(OP_CLEAR, $urandom, $urandom);
		for (int i = 0; i < n; i++) begin
			send_request(OP_APPEND, d, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255));
			d = d + ($urandom_range(0, 9) == 0 ? 0 :
				($urandom_range(0, 7) == 0 ? 32'($urandom_range(1, 32'h0FFF_FFFF)) :
				32'($urandom_range(1, 5000))));
		end
	endtask

	task automatic random_queries(int n);
		logic signed [31:0] hi;
		hi = pt_count ? pt_depth[pt_count-1] : 1000;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: send_request(OP_QUERY, $urandom, $urandom);
				1: send_request(OP_UNUSED, $urandom, $urandom);
				2: send_request(OP_QUERY, hi, '0);
				default: send_request(OP_QUERY, (hi > 0) ?
					32'($urandom_range(0, hi)) : 32'($urandom_range(0, 100)), $urandom);
			endcase
		end
	endtask

	task automatic test_random_profiles();
		for (int k = 0; k < 16; k++) begin
			if (k % 8 == 0) write_fluence($urandom_range(0, 1) ? $urandom : $urandom_range(1, 9));
			load_profile($urandom_range(0, 6));
			random_queries($urandom_range(4, 10));
		end
	endtask

	task automatic test_full_table();
		write_fluence(32'd3);
		load_profile(TABLE_SIZE);
		send_request(OP_APPEND, 32'sh7FFF_FFFF, 32'd1);
		random_queries(6);
	endtask

	task automatic test_backpressure();
		drain_results();
		long_holdoff = 1'b1;
		for (int i = 0; i < 6; i++) send_request(OP_UNUSED, $urandom, $urandom);
		while (long_holdoff) @(negedge clk);
		drain_results();
		no_stalls = 1'b1;
		load_profile(4);
		random_queries(10);
		no_stalls = 1'b0;
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = OP_APPEND;
		req.depth = '0;
		req.density = '0;
		pt_count = 0;
		flu_model = '0;
		mismatches = 0;
		long_holdoff = 1'b0;
		no_stalls = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_edges();
		test_random_profiles();
		test_full_table();
		test_backpressure();
		write_fluence(32'hFFFF_FFFF);
		test_random_profiles();
		drain_results();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_holdoff) begin
				rsp.ready <= 1'b0;
				repeat (200) @(negedge clk);
				long_holdoff = 1'b0;
			end else if (no_stalls)
				rsp.ready <= 1'b1;
			else
				rsp.ready <= $urandom_range(0, 29) == 0 ? 1'b0 :
					($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		profile_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result conc=%h status=%0d",
						rsp.concentration, rsp.status);
			end else begin
				want = expected_results.pop_front();
				if (want.concentration !== rsp.concentration ||
						want.status !== rsp.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: conc exp=%h got=%h status exp=%0d got=%0d",
							want.concentration, rsp.concentration,
							want.status, rsp.status);
				end
			end
		end
	end

	initial begin
		#300ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
